// File: hdl/swmin_pkg.sv
// ----------------------------------------------------------------------------
// swmin_pkg
// Shared widths, constants and the token type for the sliding-window
// minimum filter and its cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package swmin_pkg;

	localparam int unsigned SAMPLE_W       = 32;
	localparam int unsigned LEN_W          = 7;
	localparam int unsigned WINDOW_MAX_DEF = 64;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

	// Running minimum handed from one cell to the next.
	typedef struct packed {
		logic                       act;
		logic signed [SAMPLE_W-1:0] val;
	} tok_t;

endpackage : swmin_pkg

`default_nettype wire

// File: hdl/swmin_cell.sv
// ----------------------------------------------------------------------------
// swmin_cell
// One slot of the sample chain: holds one sample and folds it into the
// running-minimum token as the token passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module swmin_cell
	import swmin_pkg::*;
#(
	parameter int unsigned IDX = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       shift,
	input  wire logic                       adv,
	input  wire logic        [LEN_W-1:0]    window_len,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire tok_t                       tok_in,
	output      logic signed [SAMPLE_W-1:0] sample_out,
	output      tok_t                       tok_out,
	output      logic                       hit
);

	localparam int unsigned CMP_W = (LEN_W > 32) ? LEN_W : 32;
	localparam logic [CMP_W-1:0] POS = CMP_W'(IDX + 1);

	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [SAMPLE_W-1:0] tok_q;
	logic                       act_q;
	logic                       last;

	// Shift the sample chain on each accepted word.
	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= sample_in;
		end
	end

	// Advance the token unless the output side is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (adv) begin
			act_q <= tok_in.act;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_in.act) begin
			tok_q <= (sample_q < tok_in.val) ? sample_q : tok_in.val;
		end
	end

	assign last        = (CMP_W'(window_len) == POS);
	assign sample_out  = sample_q;
	assign tok_out.act = act_q & ~last;
	assign tok_out.val = tok_q;
	assign hit         = act_q & last;

endmodule : swmin_cell

`default_nettype wire

// File: hdl/sliding_window_minimum_core.sv
// ----------------------------------------------------------------------------
// sliding_window_minimum_core
// Sliding-window minimum filter over signed 32-bit samples, built as a
// chain of cells through which a running-minimum token walks.
// ----------------------------------------------------------------------------
// Every accepted sample word shifts into a chain of WINDOW_MAX cells, so
// cell i holds the sample taken i words ago. A per-sequence fill count,
// cleared to one by a word with restart set and saturating at WINDOW_MAX,
// decides whether the word yields a result: it does once the count reaches
// window_len, and never when window_len is zero or beyond WINDOW_MAX. A
// word with no result leaves the block idle for the next word. A word
// with a result starts a token at cell 0 that moves one cell per cycle
// unless stalled, taking the minimum as it goes, and stops at cell
// window_len-1; its value then goes to the output register. Such a word
// keeps the block in its sweep, with sample_ready low, until the token
// stops. A stall on the result side freezes the token walk. window_len
// resets to 1 and is to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_minimum_core
	import swmin_pkg::*;
#(
	parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// sample words in
	input  wire logic                       sample_valid,
	output      logic                       sample_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       restart,
	// minimum words out
	output      logic                       window_min_valid,
	input  wire logic                       window_min_ready,
	output      logic signed [SAMPLE_W-1:0] window_min,
	// configuration
	input  wire logic                       cfg_we,
	input  wire logic        [LEN_W-1:0]    cfg_wdata
);

	localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(WINDOW_MAX);
	localparam logic [CMP_W-1:0] LEN_LIMIT = CMP_W'(WINDOW_MAX);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	state_t                     state_q;
	logic        [LEN_W-1:0]    window_len_q;
	logic        [CNT_W-1:0]    fill_q;
	logic        [CNT_W-1:0]    fill_nxt;
	logic                       start_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic                       accept;
	logic                       produce;
	logic                       adv;
	logic                       any_hit;
	logic signed [SAMPLE_W-1:0] hit_val;
	tok_t                       tok_head;

	logic signed [SAMPLE_W-1:0] chain_sample [WINDOW_MAX];
	tok_t                       chain_tok    [WINDOW_MAX];
	logic        [WINDOW_MAX-1:0] hit_vec;

	// Take a word only between sweeps.
	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid & sample_ready;

	// Hold the token walk while a finished minimum waits to be taken.
	assign adv = ~out_valid_q | window_min_ready;

	// Fill count after this word: restart counts as the first of a sequence.
	always_comb begin
		if (restart) begin
			fill_nxt = CNT_W'(1);
		end else if (fill_q < FILL_FULL) begin
			fill_nxt = fill_q + CNT_W'(1);
		end else begin
			fill_nxt = fill_q;
		end
	end

	assign produce = (window_len_q != '0)
		&& (CMP_W'(window_len_q) <= LEN_LIMIT)
		&& (CMP_W'(fill_nxt) >= CMP_W'(window_len_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			window_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nxt;
		end
	end

	// Sweep control: one token in flight at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && produce) begin
						state_q <= ST_SWEEP;
						start_q <= 1'b1;
					end
				end
				ST_SWEEP: begin
					if (adv) begin
						start_q <= 1'b0;
						if (any_hit) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					start_q <= 1'b0;
				end
			endcase
		end
	end

	// Launch the token with the largest value so the first cell sets it.
	assign tok_head.act = start_q;
	assign tok_head.val = SAMPLE_MAX;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		if (i == 0) begin : g_head
			swmin_cell #(
				.IDX (i)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift      (accept),
				.adv        (adv),
				.window_len (window_len_q),
				.sample_in  (sample),
				.tok_in     (tok_head),
				.sample_out (chain_sample[i]),
				.tok_out    (chain_tok[i]),
				.hit        (hit_vec[i])
			);
		end else begin : g_body
			swmin_cell #(
				.IDX (i)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift      (accept),
				.adv        (adv),
				.window_len (window_len_q),
				.sample_in  (chain_sample[i-1]),
				.tok_in     (chain_tok[i-1]),
				.sample_out (chain_sample[i]),
				.tok_out    (chain_tok[i]),
				.hit        (hit_vec[i])
			);
		end
	end

	// Pick the token from the one cell that closes the window.
	always_comb begin
		hit_val = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			hit_val = hit_val | (hit_vec[i] ? chain_tok[i].val : SAMPLE_W'(0));
		end
	end

	assign any_hit = |hit_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= any_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && any_hit) begin
			out_q <= hit_val;
		end
	end

	assign window_min_valid = out_valid_q;
	assign window_min       = out_q;

	// At most one cell closes the window at a time.
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell closing the window");

	// A finished token only exists during a sweep.
	a_hit_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		any_hit |-> (state_q == ST_SWEEP))
		else $error("window hit outside a sweep");

	// A word that yields a result starts a sweep.
	a_start_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && produce) |=> (state_q == ST_SWEEP) && start_q)
		else $error("result word did not launch a sweep");

	// The fill count never passes the chain length.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill count beyond chain length");

endmodule : sliding_window_minimum_core

`default_nettype wire
